@@ sv/mft_pkg.sv @@
package mft_pkg;

   // Frame geometry defaults
   localparam int MAX_PAYLOAD    = 32;
   localparam int PREAMBLE_BYTES = 3;

   // Word timing
   localparam int          HALF_W         = 5;
   localparam int          WORD_W         = 20;
   localparam logic [HALF_W-1:0] WORD_HALF_BITS = 5'd20;
   localparam logic [WORD_W-1:0] IDLE_WORD      = 20'hAAAAA;

   // Framing bytes
   localparam logic [7:0] PRE_BYTE  = 8'hAA;
   localparam logic [7:0] SYNC_BYTE = 8'hD5;
   localparam logic [7:0] STX_BYTE  = 8'h02;
   localparam logic [7:0] ETX_BYTE  = 8'h03;

   // Item modes
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_LOAD   = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
   localparam logic [1:0] STATUS_BUSY     = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

   typedef struct packed {
      logic       accept;
      logic [1:0] mode;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       line_out;
      logic [1:0] status;
      logic       frame_busy;
   } result_type;

   // Build the 20 half-bit word: start, data LSB first, stop
   function automatic logic [WORD_W-1:0] encode_word(input logic [7:0] data_val);
      logic [WORD_W-1:0] w;
      w = 20'h00001;
      for (int b = 0; b < 8; b++) begin
         w[2 + 2*b +: 2] = data_val[b] ? 2'b10 : 2'b01;
      end
      w[19:18] = 2'b10;
      return w;
   endfunction

endpackage

@@ sv/mft_ram.sv @@
module mft_ram #(
   parameter int Width = 8,
   parameter int Depth = 32,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mft_frame_ctrl.sv @@
module mft_frame_ctrl #(
   parameter int MaxPayload   = mft_pkg::MAX_PAYLOAD,
   parameter int PreambleBytes = mft_pkg::PREAMBLE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mft_pkg::item_type    item,
   output mft_pkg::result_type  result
);

   localparam int IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
   localparam int CntW = $clog2(MaxPayload + 1);
   localparam int PosW = $clog2(PreambleBytes + MaxPayload + 4);

   localparam logic [PosW-1:0] PrePos      = PosW'(PreambleBytes);
   localparam logic [PosW-1:0] StxPos      = PosW'(PreambleBytes + 1);
   localparam logic [PosW-1:0] PayloadBase = PosW'(PreambleBytes + 2);
   localparam logic [PosW-1:0] FrameExtra  = PosW'(PreambleBytes + 3);
   localparam logic [CntW-1:0] CapCount    = CntW'(MaxPayload);

   logic [CntW-1:0] load_count_ff, load_count_in;
   logic            overflow_ff, overflow_in;
   logic [CntW-1:0] frame_length_ff, frame_length_in;
   logic [PosW-1:0] position_ff, position_in;
   logic            sending_ff, sending_in;
   logic [mft_pkg::WORD_W-1:0] shift_ff, shift_in;
   logic [mft_pkg::HALF_W-1:0] half_ff, half_in;
   logic            level_ff, level_in;

   logic [1:0]      status;
   logic [PosW-1:0] payload_end;
   logic [PosW-1:0] frame_total;
   logic [PosW-1:0] rd_offset;
   logic [IdxW-1:0] rd_addr;
   logic [7:0]      rd_data;
   logic            wr_en;
   logic [7:0]      frame_byte;

   // Payload store; entries are read only after being loaded for this frame
   mft_ram #(
      .Width (8),
      .Depth (MaxPayload)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[IdxW-1:0]),
      .wr_data (item.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Prefetch the payload entry for the current frame position
   assign payload_end = PosW'(frame_length_ff) + PayloadBase;
   assign frame_total = PosW'(frame_length_ff) + FrameExtra;
   assign rd_offset   = position_ff - PayloadBase;
   assign rd_addr     = rd_offset[IdxW-1:0];

   assign wr_en = item.accept && (item.mode == mft_pkg::MODE_LOAD) && !sending_ff &&
                  (load_count_ff < CapCount);

   // Select the frame byte for the current position
   always_comb begin
      if (position_ff < PrePos) begin
         frame_byte = mft_pkg::PRE_BYTE;
      end else if (position_ff == PrePos) begin
         frame_byte = mft_pkg::SYNC_BYTE;
      end else if (position_ff == StxPos) begin
         frame_byte = mft_pkg::STX_BYTE;
      end else if (position_ff < payload_end) begin
         frame_byte = rd_data;
      end else begin
         frame_byte = mft_pkg::ETX_BYTE;
      end
   end

   // Apply one item to the transmitter state
   always_comb begin
      load_count_in   = load_count_ff;
      overflow_in     = overflow_ff;
      frame_length_in = frame_length_ff;
      position_in     = position_ff;
      sending_in      = sending_ff;
      shift_in        = shift_ff;
      half_in         = half_ff;
      level_in        = level_ff;
      status          = mft_pkg::STATUS_NONE;

      if (item.accept) begin
         unique case (item.mode)
            mft_pkg::MODE_TICK: begin
               level_in = shift_ff[0];
               shift_in = shift_ff >> 1;
               if (half_ff <= mft_pkg::HALF_W'(1)) begin
                  // word boundary: next frame byte or idle
                  half_in  = mft_pkg::WORD_HALF_BITS;
                  shift_in = mft_pkg::IDLE_WORD;
                  if (sending_ff) begin
                     if (position_ff < frame_total) begin
                        shift_in    = mft_pkg::encode_word(frame_byte);
                        position_in = position_ff + PosW'(1);
                     end else begin
                        sending_in  = 1'b0;
                        position_in = '0;
                     end
                  end
               end else begin
                  half_in = half_ff - mft_pkg::HALF_W'(1);
               end
            end
            mft_pkg::MODE_LOAD: begin
               if (!sending_ff) begin
                  if (load_count_ff < CapCount) begin
                     load_count_in = load_count_ff + CntW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
            end
            mft_pkg::MODE_COMMIT: begin
               if (sending_ff) begin
                  status = mft_pkg::STATUS_BUSY;
               end else if (overflow_ff) begin
                  status        = mft_pkg::STATUS_TOO_LONG;
                  load_count_in = '0;
                  overflow_in   = 1'b0;
               end else begin
                  status          = mft_pkg::STATUS_ACCEPTED;
                  frame_length_in = load_count_ff;
                  position_in     = '0;
                  sending_in      = 1'b1;
                  load_count_in   = '0;
               end
            end
            default: begin
               status = mft_pkg::STATUS_NONE;
            end
         endcase
      end
   end

   assign result.line_out   = level_in;
   assign result.status     = status;
   assign result.frame_busy = sending_in;

   // Hold state; reset starts on the idle word
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff   <= '0;
         overflow_ff     <= 1'b0;
         frame_length_ff <= '0;
         position_ff     <= '0;
         sending_ff      <= 1'b0;
         shift_ff        <= mft_pkg::IDLE_WORD;
         half_ff         <= mft_pkg::WORD_HALF_BITS;
         level_ff        <= 1'b0;
      end else begin
         load_count_ff   <= load_count_in;
         overflow_ff     <= overflow_in;
         frame_length_ff <= frame_length_in;
         position_ff     <= position_in;
         sending_ff      <= sending_in;
         shift_ff        <= shift_in;
         half_ff         <= half_in;
         level_ff        <= level_in;
      end
   end

`ifndef SYNTHESIS
   a_half_range: assert property (@(posedge clock) disable iff (reset)
      (half_ff != '0) && (half_ff <= mft_pkg::WORD_HALF_BITS))
      else $error("half-bit counter out of range");

   a_no_load_in_flight: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (load_count_ff == '0) && !overflow_ff)
      else $error("load state not clear while a frame is in flight");

   a_store_frozen: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !sending_ff)
      else $error("payload store written during a frame");

   a_position_idle: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (position_ff == '0))
      else $error("frame position not parked while idle");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (position_ff <= frame_total))
      else $error("frame position past end of frame");
`endif

endmodule

@@ sv/manchester_frame_transmitter.sv @@
// Each word's result is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle while the held result is taken; the whole state update
// is combinational logic around the payload store, whose read is prefetched while a byte
// is on the line. The input stalls only while the held result is not taken.
// Reset: idle word on the line, level low, no frame pending; the payload store is not cleared.
module manchester_frame_transmitter #(
   parameter int MaxPayload    = mft_pkg::MAX_PAYLOAD,
   parameter int PreambleBytes = mft_pkg::PREAMBLE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_out,
   output logic [1:0] rsp_status,
   output logic       rsp_frame_busy
);

   mft_pkg::item_type   item;
   mft_pkg::result_type result;

   logic                rsp_valid_ff, rsp_valid_in;
   mft_pkg::result_type rsp_data_ff;
   logic                accept;

   // Take a word when the result register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign item.accept    = accept;
   assign item.mode      = req_mode;
   assign item.data_byte = req_data_byte;

   mft_frame_ctrl #(
      .MaxPayload    (MaxPayload),
      .PreambleBytes (PreambleBytes)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .result (result)
   );

   // Advance or drop the result valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_out   = rsp_data_ff.line_out;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_frame_busy = rsp_data_ff.frame_busy;

endmodule

@@ bench/tb_top.sv @@
module tb_top;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         ITEM_TARGET  = 1100;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [1:0]          mode;
      logic [7:0]          data;
      int                  reps;
      bit                  typed;
      mft_pkg::result_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = mft_pkg::MODE_TICK;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_out;
   logic [1:0] rsp_status;
   logic       rsp_frame_busy;

   // transmitter state as predicted
   logic [7:0]                 tx_store [mft_pkg::MAX_PAYLOAD];
   logic [5:0]                 tx_loaded = '0;
   logic                       tx_overrun = 1'b0;
   logic [5:0]                 tx_len = '0;
   logic [5:0]                 tx_pos = '0;
   logic                       tx_active = 1'b0;
   logic [mft_pkg::WORD_W-1:0] tx_shift = mft_pkg::IDLE_WORD;
   logic [mft_pkg::HALF_W-1:0] tx_halves = mft_pkg::WORD_HALF_BITS;
   logic                       tx_level = 1'b0;

   mft_pkg::result_type expected_results [$];
   int         error_count = 0;
   int         words_sent = 0;
   int         cycle_count = 0;
   bit         quiet_mode = 1'b0;
   bit         hold_request = 1'b0;
   int         hold_left = 0;

   // directed words: typed results only where plain after reset
   stim_row_type directed_rows [13] = '{
      '{mft_pkg::MODE_TICK,   8'h00, 1,   1'b1, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_LOAD,   8'hFF, 33,  1'b1, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_COMMIT, 8'h00, 1,   1'b1, '{1'b0, mft_pkg::STATUS_TOO_LONG, 1'b0}},
      '{MODE_SPARE,           8'hFF, 1,   1'b1, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_COMMIT, 8'h00, 1,   1'b1, '{1'b0, mft_pkg::STATUS_ACCEPTED, 1'b1}},
      '{mft_pkg::MODE_COMMIT, 8'hFF, 1,   1'b1, '{1'b0, mft_pkg::STATUS_BUSY,     1'b1}},
      '{mft_pkg::MODE_LOAD,   8'h5A, 1,   1'b1, '{1'b0, mft_pkg::STATUS_NONE,     1'b1}},
      '{mft_pkg::MODE_TICK,   8'hFF, 160, 1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_LOAD,   8'h00, 1,   1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_LOAD,   8'hFF, 1,   1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_LOAD,   8'h80, 1,   1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_COMMIT, 8'h01, 1,   1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}},
      '{mft_pkg::MODE_TICK,   8'h00, 220, 1'b0, '{1'b0, mft_pkg::STATUS_NONE,     1'b0}}
   };

   manchester_frame_transmitter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_out   (rsp_line_out),
      .rsp_status     (rsp_status),
      .rsp_frame_busy (rsp_frame_busy)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // advance the transmitter by one word and return its result
   task automatic predict_line(input logic [1:0] mode, input logic [7:0] data,
                               output mft_pkg::result_type res);
      logic [1:0] st;
      logic [7:0] byte_val;
      st = mft_pkg::STATUS_NONE;
      case (mode)
         mft_pkg::MODE_TICK: begin
            tx_level = tx_shift[0];
            tx_shift = tx_shift >> 1;
            if (tx_halves <= 1) begin
               // word boundary: next frame byte, or idle
               tx_shift = mft_pkg::IDLE_WORD;
               if (tx_active) begin
                  if (tx_pos < mft_pkg::PREAMBLE_BYTES + 3 + tx_len) begin
                     if (tx_pos < mft_pkg::PREAMBLE_BYTES)
                        byte_val = mft_pkg::PRE_BYTE;
                     else if (tx_pos == mft_pkg::PREAMBLE_BYTES)
                        byte_val = mft_pkg::SYNC_BYTE;
                     else if (tx_pos == mft_pkg::PREAMBLE_BYTES + 1)
                        byte_val = mft_pkg::STX_BYTE;
                     else if (tx_pos < mft_pkg::PREAMBLE_BYTES + 2 + tx_len)
                        byte_val = tx_store[5'(tx_pos - mft_pkg::PREAMBLE_BYTES - 2)];
                     else
                        byte_val = mft_pkg::ETX_BYTE;
                     // start (1,0) first, stop (0,1) last; a one sends low then high
                     tx_shift = {2'b10, 16'h0000, 2'b01};
                     for (int b = 0; b < 8; b++)
                        tx_shift[2 + 2*b +: 2] = {byte_val[b], ~byte_val[b]};
                     tx_pos = tx_pos + 6'd1;
                  end else begin
                     tx_active = 1'b0;
                     tx_pos = '0;
                  end
               end
               tx_halves = mft_pkg::WORD_HALF_BITS;
            end else begin
               tx_halves = tx_halves - 5'd1;
            end
         end
         mft_pkg::MODE_LOAD: begin
            if (!tx_active) begin
               if (tx_loaded < mft_pkg::MAX_PAYLOAD) begin
                  tx_store[5'(tx_loaded)] = data;
                  tx_loaded = tx_loaded + 6'd1;
               end else begin
                  tx_overrun = 1'b1;
               end
            end
         end
         mft_pkg::MODE_COMMIT: begin
            if (tx_active) begin
               st = mft_pkg::STATUS_BUSY;
            end else if (tx_overrun) begin
               st = mft_pkg::STATUS_TOO_LONG;
               tx_loaded = '0;
               tx_overrun = 1'b0;
            end else begin
               st = mft_pkg::STATUS_ACCEPTED;
               tx_len = tx_loaded;
               tx_pos = '0;
               tx_active = 1'b1;
               tx_loaded = '0;
            end
         end
         default: ;
      endcase
      res.line_out = tx_level;
      res.status = st;
      res.frame_busy = tx_active;
   endtask

   // offer one word, hold it until taken, then record its result
   task automatic send_word(input logic [1:0] mode, input logic [7:0] data,
                            input bit typed, input mft_pkg::result_type typed_res);
      mft_pkg::result_type want;
      while (!quiet_mode && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         req_mode <= 2'($urandom_range(0, 3));
         req_data_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      predict_line(mode, data, want);
      if (typed)
         want = typed_res;
      expected_results.push_back(want);
      words_sent++;
      @(negedge clock);
   endtask

   // tick out the frame in flight, with the odd stray word mixed in
   task automatic run_out_frame();
      while (tx_active) begin
         if ($urandom_range(0, 99) < 4)
            send_word(2'($urandom_range(1, 3)), 8'($urandom), 1'b0, '0);
         else
            send_word(mft_pkg::MODE_TICK, 8'($urandom), 1'b0, '0);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 9);
      end
   end

   // compare each taken result with the oldest expectation
   always @(posedge clock) begin : check_results
      mft_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_line_out !== want.line_out) begin
               $error("line_out: expected %0d, got %0d", want.line_out, rsp_line_out);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_frame_busy !== want.frame_busy) begin
               $error("frame_busy: expected %0d, got %0d", want.frame_busy,
                      rsp_frame_busy);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int  base;
      int  len;
      int  pick;
      bit  hold_done;
      bit  drain_done;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send_word(directed_rows[i].mode, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);

      // random part: mostly whole frames, some noise bursts
      base = words_sent;
      while (words_sent < base + ITEM_TARGET) begin
         if (!hold_done && words_sent >= base + 150) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         quiet_mode = (words_sent >= base + 400) && (words_sent < base + 650);
         if (!drain_done && words_sent >= base + 850) begin
            // pause until every result is back
            req_valid <= 1'b0;
            do @(negedge clock); while (expected_results.size() != 0);
            drain_done = 1'b1;
         end

         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            run_out_frame();
            pick = $urandom_range(0, 15);
            if (pick == 0)
               len = mft_pkg::MAX_PAYLOAD;
            else if (pick == 1)
               len = $urandom_range(mft_pkg::MAX_PAYLOAD + 1, mft_pkg::MAX_PAYLOAD + 4);
            else if (pick < 4)
               len = $urandom_range(5, mft_pkg::MAX_PAYLOAD - 1);
            else
               len = $urandom_range(0, 4);
            for (int n = 0; n < len; n++) begin
               if ($urandom_range(0, 9) == 0)
                  send_word(mft_pkg::MODE_TICK, 8'($urandom), 1'b0, '0);
               send_word(mft_pkg::MODE_LOAD, 8'($urandom), 1'b0, '0);
            end
            send_word(mft_pkg::MODE_COMMIT, 8'($urandom), 1'b0, '0);
            run_out_frame();
            repeat ($urandom_range(0, 25))
               send_word(mft_pkg::MODE_TICK, 8'($urandom), 1'b0, '0);
         end else begin
            repeat ($urandom_range(5, 30))
               send_word(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
         end
      end
      quiet_mode = 1'b0;
      req_valid <= 1'b0;

      // drain, then keep watching for stray results
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mft_pkg.sv
sv/mft_ram.sv
sv/mft_frame_ctrl.sv
sv/manchester_frame_transmitter.sv
bench/tb_top.sv
